### rtl/tnt_pkg.sv
package tnt_pkg;

  // Field and datapath widths
  localparam int COORD_W  = 16;
  localparam int IDX_W    = 10;
  localparam int VERT_DEPTH = 1 << IDX_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int RES_W    = PROD_W + 1;
  localparam int MAG_W    = 30;
  localparam int HALF_W   = MAG_W / 2;
  localparam int MAX_SH   = RES_W - MAG_W;
  localparam int SUM_W    = 62;
  localparam int LEN_W    = 31;
  localparam int UNIT_W   = 16;
  localparam int UNIT_ONE = 16384;
  localparam int QUO_W    = 15;
  localparam int NUM_W    = MAG_W + QUO_W + 1;
  localparam int N_TERMS  = 10;
  localparam int N_STEPS  = 2 * N_TERMS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [IDX_W-1:0]   idx_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [RES_W-1:0]   wide_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TRI  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_EN_NORM    = 2'd0,
    CFG_EN_TAN     = 2'd1,
    CFG_SWAP       = 2'd2,
    CFG_SWAP_FIRST = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic en_norm;
    logic en_tan;
    logic swap;
    logic swap_first;
  } cfg_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t tu;
    coord_t tv;
  } vert_t;

  typedef struct packed {
    op_t    op;
    idx_t   vertex_slot;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
    idx_t   corner0;
    idx_t   corner1;
    idx_t   corner2;
  } in_item_t;

  typedef struct packed {
    unit_t normal_x;
    unit_t normal_y;
    unit_t normal_z;
    unit_t tangent_x;
    unit_t tangent_y;
    unit_t tangent_z;
    unit_t bitangent_x;
    unit_t bitangent_y;
    unit_t bitangent_z;
    idx_t  out_corner0;
    idx_t  out_corner1;
    idx_t  out_corner2;
  } out_item_t;

  // Classified item held in the queue
  typedef struct packed {
    op_t   op;
    idx_t  slot;
    vert_t vert;
    idx_t  w0;
    idx_t  w1;
    idx_t  w2;
    idx_t  c0;
    idx_t  c1;
    idx_t  c2;
  } q_item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RD0, B_RD1, B_RD2, B_RD3, B_DIFF, B_MUL, B_NGO, B_NWAIT, B_OUT
  } back_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQL, N_SQRT, N_LEN, N_DSET, N_DIV, N_DFIN, N_DONE
  } norm_state_t;

endpackage

### rtl/tnt_front.sv
module tnt_front import tnt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_pop,
  output logic     q_valid,
  output q_item_t  q_data
);

  localparam int QD = 2;

  q_item_t    fifo_r [QD];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  q_item_t    ent;
  logic       push;

  // Classify: winding swap for the reported corners and the fetched corners
  always_comb begin
    ent.op   = in_data.op;
    ent.slot = in_data.vertex_slot;
    ent.vert = '{px: in_data.pos_x, py: in_data.pos_y, pz: in_data.pos_z,
                 tu: in_data.tex_u, tv: in_data.tex_v};
    ent.c1   = in_data.corner1;
    ent.w1   = in_data.corner1;
    ent.c0   = cfg.swap ? in_data.corner2 : in_data.corner0;
    ent.c2   = cfg.swap ? in_data.corner0 : in_data.corner2;
    ent.w0   = (cfg.swap && cfg.swap_first) ? in_data.corner2 : in_data.corner0;
    ent.w2   = (cfg.swap && cfg.swap_first) ? in_data.corner0 : in_data.corner2;
  end

  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  // Two-entry queue towards the back end
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/tnt_norm.sv
module tnt_norm import tnt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  wide_t vec [3],
  output logic  done,
  output unit_t res [3]
);

  norm_state_t state_r, state_nxt;

  wide_t              vin_r [3];
  logic [RES_W-1:0]   mag_r [3];
  logic [MAG_W-1:0]   sm_r  [3];
  logic [1:0]         comp_r, part_r, prev_part_r;
  logic [MAG_W-1:0]   pp_r;
  logic [SUM_W-1:0]   sum_r, n_r, r_r;
  logic [4:0]         k_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W:0]     rem_r;
  logic [QUO_W-1:0]   lo_r, q_r;
  logic [3:0]         qi_r;
  unit_t              res_r [3];

  logic [RES_W-1:0]   m;
  logic [2:0]         s;
  logic [HALF_W-1:0]  op_a, op_b;
  logic [SUM_W-1:0]   pp_sh, bitv, trial;
  logic [NUM_W-1:0]   num;
  logic [LEN_W+1:0]   rem2, dsor;
  logic               ge;

  // Largest magnitude and the scaling shift that brings it below 2^30
  always_comb begin
    m = mag_r[0];
    if (mag_r[1] > m) m = mag_r[1];
    if (mag_r[2] > m) m = mag_r[2];
    s = 3'd0;
    for (int j = MAX_SH; j >= 0; j--) begin
      if ({1'b0, m} < ((RES_W + 1)'(1) << (MAG_W + j))) s = 3'(j);
    end
  end

  // Squares as three 15x15 partial products
  always_comb begin
    case (part_r)
      2'd0:    begin op_a = sm_r[comp_r][MAG_W-1:HALF_W]; op_b = op_a; end
      2'd1:    begin op_a = sm_r[comp_r][MAG_W-1:HALF_W];
                     op_b = sm_r[comp_r][HALF_W-1:0]; end
      default: begin op_a = sm_r[comp_r][HALF_W-1:0]; op_b = op_a; end
    endcase
    case (prev_part_r)
      2'd0:    pp_sh = SUM_W'(pp_r) << (2 * HALF_W);
      2'd1:    pp_sh = SUM_W'(pp_r) << (HALF_W + 1);
      default: pp_sh = SUM_W'(pp_r);
    endcase
  end

  // Root step and divide step
  always_comb begin
    bitv  = SUM_W'(1) << {k_r, 1'b0};
    trial = r_r + bitv;
    num   = NUM_W'(sm_r[comp_r]) * NUM_W'(2 * UNIT_ONE) + NUM_W'(len_r);
    rem2  = {rem_r, lo_r[QUO_W-1]};
    dsor  = (LEN_W + 2)'({len_r, 1'b0});
    ge    = (rem2 >= dsor);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      N_IDLE:  if (start) state_nxt = N_SHIFT;
      N_SHIFT: state_nxt = N_SQ;
      N_SQ:    if (comp_r == 2'd2 && part_r == 2'd2) state_nxt = N_SQL;
      N_SQL:   state_nxt = N_SQRT;
      N_SQRT:  if (k_r == 5'd0) state_nxt = N_LEN;
      N_LEN:   state_nxt = (r_r == '0) ? N_DONE : N_DSET;
      N_DSET:  state_nxt = N_DIV;
      N_DIV:   if (qi_r == 4'(QUO_W - 1)) state_nxt = N_DFIN;
      N_DFIN:  state_nxt = (comp_r == 2'd2) ? N_DONE : N_DSET;
      N_DONE:  begin done = 1'b1; state_nxt = N_IDLE; end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          vin_r[i] <= vec[i];
          mag_r[i] <= vec[i][RES_W-1] ? unsigned'(-vec[i]) : unsigned'(vec[i]);
        end
      end
      N_SHIFT: begin
        for (int i = 0; i < 3; i++) sm_r[i] <= MAG_W'(mag_r[i] >> s);
        comp_r <= 2'd0;
        part_r <= 2'd0;
        sum_r  <= '0;
      end
      N_SQ: begin
        pp_r        <= MAG_W'(op_a * op_b);
        prev_part_r <= part_r;
        if (!(comp_r == 2'd0 && part_r == 2'd0)) sum_r <= sum_r + pp_sh;
        if (part_r == 2'd2) begin
          part_r <= 2'd0;
          comp_r <= comp_r + 2'd1;
        end else begin
          part_r <= part_r + 2'd1;
        end
      end
      N_SQL: begin
        n_r <= sum_r + pp_sh;
        r_r <= '0;
        k_r <= 5'(LEN_W - 1);
      end
      N_SQRT: begin
        if (n_r >= trial) begin
          n_r <= n_r - trial;
          r_r <= (r_r >> 1) + bitv;
        end else begin
          r_r <= r_r >> 1;
        end
        k_r <= k_r - 5'd1;
      end
      N_LEN: begin
        len_r  <= r_r[LEN_W-1:0];
        comp_r <= 2'd0;
        if (r_r == '0) begin
          for (int i = 0; i < 3; i++) res_r[i] <= '0;
        end
      end
      N_DSET: begin
        rem_r <= (LEN_W + 1)'(num[NUM_W-1:QUO_W]);
        lo_r  <= num[QUO_W-1:0];
        q_r   <= '0;
        qi_r  <= 4'd0;
      end
      N_DIV: begin
        rem_r <= ge ? (LEN_W + 1)'(rem2 - dsor) : (LEN_W + 1)'(rem2);
        lo_r  <= lo_r << 1;
        q_r   <= {q_r[QUO_W-2:0], ge};
        qi_r  <= qi_r + 4'd1;
      end
      N_DFIN: begin
        res_r[comp_r] <= vin_r[comp_r][RES_W-1] ? -UNIT_W'(q_r) : UNIT_W'(q_r);
        comp_r        <= comp_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule

### rtl/tnt_back.sv
module tnt_back import tnt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  vert_t mem [VERT_DEPTH];
  vert_t rd_data_r;
  idx_t  rd_addr;
  logic  rd_en, mem_we;

  back_state_t state_r, state_nxt;
  q_item_t     ent_r;
  vert_t       v_r [3];
  diff_t       e0_r [3], e1_r [3], d0_r [2], d1_r [2];
  logic [4:0]  step_r, prev;
  prod_t       mul_r, tmp_r;
  diff_t       op_a, op_b;
  wide_t       term_r [N_TERMS];
  logic [1:0]  vsel_r;
  wide_t       nvec [3];
  logic        nstart, ndone;
  unit_t       nres [3];
  unit_t       ures_r [3][3];
  logic        out_valid_r, out_load, det_neg, tan_ok;
  out_item_t   out_r, out_nxt;

  tnt_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nstart),
    .vec   (nvec),
    .done  (ndone),
    .res   (nres)
  );

  // Vertex table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_data.slot] <= q_data.vert;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Operand select for the product sequence: ten terms a*b - c*d
  always_comb begin
    case (step_r)
      5'd0:    begin op_a = e0_r[1]; op_b = e1_r[2]; end
      5'd1:    begin op_a = e0_r[2]; op_b = e1_r[1]; end
      5'd2:    begin op_a = e0_r[2]; op_b = e1_r[0]; end
      5'd3:    begin op_a = e0_r[0]; op_b = e1_r[2]; end
      5'd4:    begin op_a = e0_r[0]; op_b = e1_r[1]; end
      5'd5:    begin op_a = e0_r[1]; op_b = e1_r[0]; end
      5'd6:    begin op_a = d0_r[0]; op_b = d1_r[1]; end
      5'd7:    begin op_a = d1_r[0]; op_b = d0_r[1]; end
      5'd8:    begin op_a = d1_r[1]; op_b = e0_r[0]; end
      5'd9:    begin op_a = d0_r[1]; op_b = e1_r[0]; end
      5'd10:   begin op_a = d1_r[1]; op_b = e0_r[1]; end
      5'd11:   begin op_a = d0_r[1]; op_b = e1_r[1]; end
      5'd12:   begin op_a = d1_r[1]; op_b = e0_r[2]; end
      5'd13:   begin op_a = d0_r[1]; op_b = e1_r[2]; end
      5'd14:   begin op_a = d1_r[0]; op_b = e0_r[0]; end
      5'd15:   begin op_a = d0_r[0]; op_b = e1_r[0]; end
      5'd16:   begin op_a = d1_r[0]; op_b = e0_r[1]; end
      5'd17:   begin op_a = d0_r[0]; op_b = e1_r[1]; end
      5'd18:   begin op_a = d1_r[0]; op_b = e0_r[2]; end
      5'd19:   begin op_a = d0_r[0]; op_b = e1_r[2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prev    = step_r - 5'd1;
  assign det_neg = term_r[3][RES_W-1];
  assign tan_ok  = cfg.en_tan && (term_r[3] != '0);

  // Vector handed to the normalizer: face normal, tangent, bitangent
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (vsel_r)
        2'd0:    nvec[i] = term_r[i];
        2'd1:    nvec[i] = det_neg ? -term_r[4 + i] : term_r[4 + i];
        default: nvec[i] = det_neg ? -term_r[7 + i] : term_r[7 + i];
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ent_r.w0;
    nstart    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.op == OP_LOAD) mem_we = 1'b1;
          else state_nxt = B_RD0;
        end
      end
      B_RD0: begin rd_en = 1'b1; rd_addr = ent_r.w0; state_nxt = B_RD1; end
      B_RD1: begin rd_en = 1'b1; rd_addr = ent_r.w1; state_nxt = B_RD2; end
      B_RD2: begin rd_en = 1'b1; rd_addr = ent_r.w2; state_nxt = B_RD3; end
      B_RD3: state_nxt = B_DIFF;
      B_DIFF: state_nxt = B_MUL;
      B_MUL: if (step_r == 5'(N_STEPS)) state_nxt = B_NGO;
      B_NGO: begin nstart = 1'b1; state_nxt = B_NWAIT; end
      B_NWAIT: if (ndone) state_nxt = (vsel_r == 2'd2) ? B_OUT : B_NGO;
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (q_valid) ent_r <= q_data;
      B_RD1:  v_r[0] <= rd_data_r;
      B_RD2:  v_r[1] <= rd_data_r;
      B_RD3:  v_r[2] <= rd_data_r;
      B_DIFF: begin
        e0_r[0] <= DIFF_W'(v_r[1].px) - DIFF_W'(v_r[0].px);
        e0_r[1] <= DIFF_W'(v_r[1].py) - DIFF_W'(v_r[0].py);
        e0_r[2] <= DIFF_W'(v_r[1].pz) - DIFF_W'(v_r[0].pz);
        e1_r[0] <= DIFF_W'(v_r[2].px) - DIFF_W'(v_r[0].px);
        e1_r[1] <= DIFF_W'(v_r[2].py) - DIFF_W'(v_r[0].py);
        e1_r[2] <= DIFF_W'(v_r[2].pz) - DIFF_W'(v_r[0].pz);
        d0_r[0] <= DIFF_W'(v_r[1].tu) - DIFF_W'(v_r[0].tu);
        d0_r[1] <= DIFF_W'(v_r[1].tv) - DIFF_W'(v_r[0].tv);
        d1_r[0] <= DIFF_W'(v_r[2].tu) - DIFF_W'(v_r[0].tu);
        d1_r[1] <= DIFF_W'(v_r[2].tv) - DIFF_W'(v_r[0].tv);
        step_r  <= 5'd0;
        vsel_r  <= 2'd0;
      end
      B_MUL: begin
        if (step_r != 5'(N_STEPS)) begin
          mul_r  <= op_a * op_b;
          step_r <= step_r + 5'd1;
        end
        if (step_r != 5'd0) begin
          if (!prev[0]) tmp_r <= mul_r;
          else term_r[prev[4:1]] <= RES_W'(tmp_r) - RES_W'(mul_r);
        end
      end
      B_NWAIT: begin
        if (ndone) begin
          ures_r[vsel_r] <= nres;
          vsel_r         <= vsel_r + 2'd1;
        end
      end
      default: ;
    endcase
    if (out_load) out_r <= out_nxt;
  end

  // Result assembly with the enables applied
  always_comb begin
    out_nxt.normal_x    = cfg.en_norm ? ures_r[0][0] : '0;
    out_nxt.normal_y    = cfg.en_norm ? ures_r[0][1] : '0;
    out_nxt.normal_z    = cfg.en_norm ? ures_r[0][2] : '0;
    out_nxt.tangent_x   = tan_ok ? ures_r[1][0] : '0;
    out_nxt.tangent_y   = tan_ok ? ures_r[1][1] : '0;
    out_nxt.tangent_z   = tan_ok ? ures_r[1][2] : '0;
    out_nxt.bitangent_x = tan_ok ? ures_r[2][0] : '0;
    out_nxt.bitangent_y = tan_ok ? ures_r[2][1] : '0;
    out_nxt.bitangent_z = tan_ok ? ures_r[2][2] : '0;
    out_nxt.out_corner0 = ent_r.c0;
    out_nxt.out_corner1 = ent_r.c1;
    out_nxt.out_corner2 = ent_r.c2;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/triangle_normal_tangent_unit.sv
// Triangle face normal and tangent frame. Load items write one vertex (position and
// texture coordinate) into a 1024-entry table; triangle items read three entries and
// return one result with the unit normal, unit tangent and negated unit bitangent in
// Q1.14 plus the corner indices after the optional winding swap. Items pass through a
// two-entry queue into the back end, so the input takes up to two items while a triangle
// is worked on. A load writes the table without leaving the idle state. A triangle goes
// through three table reads, twenty products through one 17x17 multiplier, then three
// passes of a shared normalizer (nine partial squares, a 31-step square root and three
// 15-step divides each). Table entries never written since reset read as undefined
// values.
module triangle_normal_tangent_unit import tnt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [0:0] cfg_data
);

  cfg_t    cfg_r;
  logic    q_valid, q_pop;
  q_item_t q_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EN_NORM:    cfg_r.en_norm    <= cfg_data[0];
        CFG_EN_TAN:     cfg_r.en_tan     <= cfg_data[0];
        CFG_SWAP:       cfg_r.swap       <= cfg_data[0];
        CFG_SWAP_FIRST: cfg_r.swap_first <= cfg_data[0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  tnt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  tnt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/triangle_normal_tangent_unit_tb.sv
module triangle_normal_tangent_unit_tb import tnt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 800;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [0:0] cfg_data;

  triangle_normal_tangent_unit dut (.*);

  // Local copy of the vertex table and settings
  logic signed [15:0] tbl_pos [0:1023][0:2];
  logic signed [15:0] tbl_tex [0:1023][0:1];
  bit               written [0:1023];
  cfg_t             mode;
  out_item_t        frames_due [$];
  int               errors;
  int               tri_count;
  int               load_count;
  int               quiet_cycles;
  bit               stall_burst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Scale a vector to Q1.14, rounding halves away from zero
  function automatic void unit_vec(input logic signed [63:0] v [0:2],
                                   output unit_t o [0:2]);
    logic [63:0] mag [0:2];
    logic [63:0] m, sum, len, rem, bitv, q;
    int s;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    s = 0;
    while ((m >> s) >= 64'd1 << 30) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum += mag[i] * mag[i];
    end
    // integer square root
    len = 0;
    rem = sum;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem -= len + bitv;
        len = (len >> 1) + bitv;
      end else begin
        len >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = '0;
      end else begin
        q = (mag[i] * (2 * UNIT_ONE) + len) / (2 * len);
        o[i] = v[i] < 0 ? unit_t'(-q) : unit_t'(q);
      end
    end
  endfunction

  function automatic void vertex_of(input idx_t k, output logic signed [63:0] p [0:2],
                                    output logic signed [63:0] t [0:1]);
    for (int i = 0; i < 3; i++) p[i] = tbl_pos[k][i];
    for (int i = 0; i < 2; i++) t[i] = tbl_tex[k][i];
  endfunction

  // Work out the frame one triangle item yields
  function automatic out_item_t triangle_frame(input in_item_t it);
    idx_t c [0:2];
    idx_t w [0:2];
    logic signed [63:0] p [0:2][0:2];
    logic signed [63:0] t [0:2][0:1];
    logic signed [63:0] e0 [0:2];
    logic signed [63:0] e1 [0:2];
    logic signed [63:0] d0 [0:1];
    logic signed [63:0] d1 [0:1];
    logic signed [63:0] cr [0:2];
    logic signed [63:0] tr [0:2];
    logic signed [63:0] br [0:2];
    logic signed [63:0] det;
    unit_t nv [0:2];
    unit_t tv [0:2];
    unit_t bv [0:2];
    out_item_t r;
    c[0] = it.corner0;
    c[1] = it.corner1;
    c[2] = it.corner2;
    if (mode.swap) begin
      c[0] = it.corner2;
      c[2] = it.corner0;
    end
    w = c;
    if (mode.swap && !mode.swap_first) begin
      w[0] = c[2];
      w[2] = c[0];
    end
    for (int i = 0; i < 3; i++) vertex_of(w[i], p[i], t[i]);
    for (int i = 0; i < 3; i++) begin
      e0[i] = p[1][i] - p[0][i];
      e1[i] = p[2][i] - p[0][i];
      nv[i] = '0;
      tv[i] = '0;
      bv[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      d0[i] = t[1][i] - t[0][i];
      d1[i] = t[2][i] - t[0][i];
    end
    if (mode.en_norm) begin
      cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
      cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
      cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
      unit_vec(cr, nv);
    end
    if (mode.en_tan) begin
      det = d0[0] * d1[1] - d1[0] * d0[1];
      if (det != 0) begin
        for (int i = 0; i < 3; i++) begin
          tr[i] = d1[1] * e0[i] - d0[1] * e1[i];
          br[i] = d1[0] * e0[i] - d0[0] * e1[i];
          if (det < 0) begin
            tr[i] = -tr[i];
            br[i] = -br[i];
          end
        end
        unit_vec(tr, tv);
        unit_vec(br, bv);
      end
    end
    r.normal_x = nv[0];
    r.normal_y = nv[1];
    r.normal_z = nv[2];
    r.tangent_x = tv[0];
    r.tangent_y = tv[1];
    r.tangent_z = tv[2];
    r.bitangent_x = bv[0];
    r.bitangent_y = bv[1];
    r.bitangent_z = bv[2];
    r.out_corner0 = c[0];
    r.out_corner1 = c[1];
    r.out_corner2 = c[2];
    return r;
  endfunction

  // Send one item, then update the local table or queue the expected frame
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_LOAD) begin
      tbl_pos[it.vertex_slot][0] = it.pos_x;
      tbl_pos[it.vertex_slot][1] = it.pos_y;
      tbl_pos[it.vertex_slot][2] = it.pos_z;
      tbl_tex[it.vertex_slot][0] = it.tex_u;
      tbl_tex[it.vertex_slot][1] = it.tex_v;
      written[it.vertex_slot] = 1'b1;
      load_count++;
    end else begin
      frames_due.push_back(triangle_frame(it));
      tri_count++;
    end
  endtask

  task automatic load_vertex(input idx_t k, input coord_t x, input coord_t y,
                             input coord_t z, input coord_t u, input coord_t v);
    in_item_t it;
    it = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.op = OP_LOAD;
    it.vertex_slot = k;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_u = u;
    it.tex_v = v;
    send_item(it);
  endtask

  task automatic process_triangle(input idx_t a, input idx_t b, input idx_t c);
    in_item_t it;
    it = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.op = OP_TRI;
    it.corner0 = a;
    it.corner1 = b;
    it.corner2 = c;
    send_item(it);
  endtask

  function automatic idx_t any_written();
    idx_t k;
    do k = idx_t'($urandom()); while (!written[k]);
    return k;
  endfunction

  // Drop the input, wait for all frames, then for the back end to fall quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_EN_NORM:    mode.en_norm = val;
      CFG_EN_TAN:     mode.en_tan = val;
      CFG_SWAP:       mode.swap = val;
      CFG_SWAP_FIRST: mode.swap_first = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input cfg_t m);
    drain();
    write_reg(CFG_EN_NORM, m.en_norm);
    write_reg(CFG_EN_TAN, m.en_tan);
    write_reg(CFG_SWAP, m.swap);
    write_reg(CFG_SWAP_FIRST, m.swap_first);
  endtask

  // Extremes of coordinates, degenerate and zero-determinant triangles
  task automatic test_directed();
    load_vertex(10'd0, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7fff);
    load_vertex(10'd1023, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    load_vertex(10'd512, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000);
    load_vertex(10'd1, 16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000, 16'sh0000);
    load_vertex(10'd2, 16'sh0000, 16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000);
    load_vertex(10'd3, 16'sh2000, 16'sh0000, 16'sh0000, 16'sh2000, 16'sh0000);
    load_vertex(10'd4, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    load_vertex(10'd341, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    load_vertex(10'd682, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    process_triangle(10'd0, 10'd1023, 10'd512);
    process_triangle(10'd0, 10'd1, 10'd2);
    process_triangle(10'd2, 10'd1, 10'd0);
    // all corners the same: zero vectors
    process_triangle(10'd1, 10'd1, 10'd1);
    // points 1 and 3 on the x axis, UVs 1 and 3 on the u axis
    process_triangle(10'd0, 10'd1, 10'd3);
    process_triangle(10'd341, 10'd682, 10'd4);
    process_triangle(10'd1023, 10'd512, 10'd0);
    process_triangle(10'd682, 10'd341, 10'd1023);
  endtask

  // One mesh per pass: loads mixed with triangles over loaded slots, a little noise
  task automatic test_random_mesh(input int n_items);
    int r;
    idx_t k;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = idx_t'($urandom_range(0, 99) < 70 ? $urandom_range(0, 63) : $urandom());
        load_vertex(k, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                    coord_t'($urandom()), coord_t'($urandom()));
      end else if (r < 40) begin
        // small coordinates, many shared values: degenerate cases
        k = idx_t'($urandom_range(0, 63));
        load_vertex(k, coord_t'($urandom_range(0, 2)), coord_t'($urandom_range(0, 2)),
                    coord_t'($urandom_range(0, 2)), coord_t'($urandom_range(0, 1)),
                    coord_t'($urandom_range(0, 1)));
      end else begin
        process_triangle(any_written(), any_written(), any_written());
      end
    end
  endtask

  // Result side: random stall, compare each frame
  initial begin
    out_stall <= 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 499) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end else if (stall_burst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame %h", $realtime, out_data);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (out_data !== want) begin
          $display("%0t: frame mismatch expected %h actual %h", $realtime, want, out_data);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cfg_t m;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EN_NORM;
    cfg_data = 1'b0;
    errors = 0;
    tri_count = 0;
    load_count = 0;
    quiet_cycles = 0;
    stall_burst = 1'b0;
    mode = '0;
    for (int i = 0; i < 1024; i++) written[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: everything off, corners only
    test_directed();
    set_mode('{en_norm: 1'b1, en_tan: 1'b1, swap: 1'b0, swap_first: 1'b0});
    test_directed();
    set_mode('{en_norm: 1'b1, en_tan: 1'b1, swap: 1'b1, swap_first: 1'b1});
    test_directed();
    set_mode('{en_norm: 1'b1, en_tan: 1'b0, swap: 1'b1, swap_first: 1'b0});
    test_directed();
    stall_burst = 1'b1;
    test_random_mesh(150);
    stall_burst = 1'b0;
    for (int p = 0; p < 8; p++) begin
      m = cfg_t'($urandom());
      if (p < 4) m.en_norm = 1'b1;
      if (p < 4) m.en_tan = 1'b1;
      set_mode(m);
      test_random_mesh(180);
    end
    drain();

    $display("Covered %0d vertex loads and %0d triangles over several settings.",
             load_count, tri_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### triangle_normal_tangent_unit.f
rtl/tnt_pkg.sv
rtl/tnt_front.sv
rtl/tnt_norm.sv
rtl/tnt_back.sv
rtl/triangle_normal_tangent_unit.sv
test/triangle_normal_tangent_unit_tb.sv
